>>> rtl/trst_pkg.sv
// Package for the triple ranked slot table: sizes, opcodes and shared types.
// No dependencies; imported by every module of the block.
package trst_pkg;
    localparam int SLOTS = 32;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    typedef struct packed {
        logic [31:0] location;
        logic [7:0]  food;
        logic [7:0]  production;
        logic [7:0]  gold;
    } t_payload;

    typedef struct packed {
        logic       load;    // capture input word
        logic       exec;    // apply the operation
        logic       emit;    // register the result word
    } t_cmd;

    typedef struct packed {
        logic dummy_ok;
    } t_status;

    // 24-bit key for list k: leading value then two tie-breakers
    function automatic logic [23:0] rank_key(input logic [1:0] k, input t_payload p);
        logic [23:0] r;
        case (k)
            2'd0:    r = {p.food, p.production, p.gold};
            2'd1:    r = {p.production, p.food, p.gold};
            default: r = {p.gold, p.food, p.production};
        endcase
        return r;
    endfunction
endpackage

>>> rtl/triple_ranked_slot_table.sv
// Triple ranked slot table: 32 slots with three ranked lists of slot numbers.
// A word is taken through load, rank chain update and result register steps:
// its result word is presented once registered, and a new word is accepted
// only after the previous result is registered; a stalled output holds
// the block in its result step. Synchronous active-low reset empties the
// table and all lists at once; no clearing pass. Depends on trst_pkg.
module triple_ranked_slot_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [4:0]        i_slot_index,
    input  logic [31:0]       i_location,
    input  logic [7:0]        i_food,
    input  logic [7:0]        i_production,
    input  logic [7:0]        i_gold,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_ok,
    output logic [4:0]        o_slot_assigned,
    output logic [31:0]       o_entry_location,
    output logic [7:0]        o_entry_food,
    output logic [7:0]        o_entry_production,
    output logic [7:0]        o_entry_gold,
    output logic signed [5:0] o_head_food,
    output logic signed [5:0] o_head_production,
    output logic signed [5:0] o_head_gold,
    output logic [5:0]        o_live_count
);
    import trst_pkg::*;

    t_cmd cmd;

    trst_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_cmd(cmd)
    );

    trst_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_opcode, .i_slot_index, .i_location,
        .i_food, .i_production, .i_gold, .o_ok, .o_slot_assigned,
        .o_entry_location, .o_entry_food, .o_entry_production, .o_entry_gold,
        .o_head_food, .o_head_production, .o_head_gold, .o_live_count
    );
endmodule

>>> rtl/trst_ctrl.sv
// Controller of the triple ranked slot table: load, execute, emit sequence.
// Depends on trst_pkg.
module trst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output trst_pkg::t_cmd  o_cmd
);
    import trst_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || !i_stall) begin
                    o_cmd.emit = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_emit_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> r_state == S_OUT) else $error("emit outside output state");
    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec) else $error("exec did not follow load");
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> o_valid) else $error("result not presented");
endmodule

>>> rtl/trst_datapath.sv
// Datapath of the triple ranked slot table: slot store, three shifting rank
// chains of compare cells and the result register. Depends on trst_pkg.
module trst_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  trst_pkg::t_cmd       i_cmd,
    input  logic [1:0]           i_opcode,
    input  logic [4:0]           i_slot_index,
    input  logic [31:0]          i_location,
    input  logic [7:0]           i_food,
    input  logic [7:0]           i_production,
    input  logic [7:0]           i_gold,
    output logic                 o_ok,
    output logic [4:0]           o_slot_assigned,
    output logic [31:0]          o_entry_location,
    output logic [7:0]           o_entry_food,
    output logic [7:0]           o_entry_production,
    output logic [7:0]           o_entry_gold,
    output logic signed [5:0]    o_head_food,
    output logic signed [5:0]    o_head_production,
    output logic signed [5:0]    o_head_gold,
    output logic [5:0]           o_live_count
);
    import trst_pkg::*;

    // input word
    logic [1:0]    r_op;
    logic [SW-1:0] r_idx;
    t_payload      r_in;

    // slot store and valid bits
    t_payload      r_pay [SLOTS];
    logic [SLOTS-1:0] r_valid;
    logic [CW-1:0] r_used, r_live;

    // rank chains: slot number and a copy of the key in every cell
    logic [SW-1:0] r_rs [3][SLOTS];
    logic [23:0]   r_rk [3][SLOTS];
    logic [CW-1:0] r_len [3];

    // result of the exec step
    logic          r_ok;
    logic [SW-1:0] r_asg;
    t_payload      r_shown;

    // result word register
    logic          r_o_ok;
    logic [SW-1:0] r_o_asg;
    t_payload      r_o_pay;
    logic [5:0]    r_o_head [3];
    logic [5:0]    r_o_live;

    logic ins_ok, rd_ok;
    assign ins_ok = (r_used < CW'(SLOTS));
    assign rd_ok  = r_valid[r_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_idx <= i_slot_index[SW-1:0];
            r_in  <= '{location: i_location, food: i_food,
                       production: i_production, gold: i_gold};
        end
    end

    // per-chain key, membership and match vectors
    logic [23:0]      nk [3];
    logic             nin [3];
    logic [SLOTS-1:0] beat [3];
    logic [SLOTS-1:0] hit [3];
    logic [SLOTS-1:0] past [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nk[k]  = rank_key(2'(k), r_in);
            nin[k] = (nk[k][23:16] != 8'd0);
            for (int j = 0; j < SLOTS; j++) begin
                beat[k][j] = (CW'(j) < r_len[k]) && (nk[k] > r_rk[k][j]);
                hit[k][j]  = (CW'(j) < r_len[k]) && (r_rs[k][j] == r_idx);
            end
            // past[j]: the removed slot sits at or before cell j
            past[k][0] = hit[k][0];
            for (int j = 1; j < SLOTS; j++) begin
                past[k][j] = past[k][j-1] | hit[k][j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            r_live  <= '0;
            for (int k = 0; k < 3; k++) r_len[k] <= '0;
        end else if (i_cmd.exec) begin
            r_ok    <= 1'b0;
            r_asg   <= '0;
            r_shown <= '0;
            case (r_op)
                OP_CLEAR: begin
                    r_ok    <= 1'b1;
                    r_valid <= '0;
                    r_used  <= '0;
                    r_live  <= '0;
                    for (int k = 0; k < 3; k++) r_len[k] <= '0;
                end
                OP_INSERT: begin
                    if (ins_ok) begin
                        r_ok <= 1'b1;
                        r_asg <= r_used[SW-1:0];
                        r_pay[r_used[SW-1:0]] <= r_in;
                        r_valid[r_used[SW-1:0]] <= 1'b1;
                        r_used <= r_used + 1'b1;
                        r_live <= r_live + 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            if (nin[k]) begin
                                r_len[k] <= r_len[k] + 1'b1;
                                // cells the new key beats shift down one; the
                                // first such cell (or the tail) takes the new key
                                for (int j = 0; j < SLOTS; j++) begin
                                    if (beat[k][j]) begin
                                        if (j == 0 || !beat[k][(j == 0) ? 0 : j-1]) begin
                                            r_rs[k][j] <= r_used[SW-1:0];
                                            r_rk[k][j] <= nk[k];
                                        end else begin
                                            r_rs[k][j] <= r_rs[k][(j == 0) ? 0 : j-1];
                                            r_rk[k][j] <= r_rk[k][(j == 0) ? 0 : j-1];
                                        end
                                    end else if (CW'(j) == r_len[k]) begin
                                        if (j != 0 && beat[k][(j == 0) ? 0 : j-1]) begin
                                            r_rs[k][j] <= r_rs[k][(j == 0) ? 0 : j-1];
                                            r_rk[k][j] <= r_rk[k][(j == 0) ? 0 : j-1];
                                        end else begin
                                            r_rs[k][j] <= r_used[SW-1:0];
                                            r_rk[k][j] <= nk[k];
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                    if (rd_ok) begin
                        r_ok    <= 1'b1;
                        r_shown <= r_pay[r_idx];
                        if (r_op == OP_REMOVE) begin
                            r_valid[r_idx] <= 1'b0;
                            r_live <= r_live - 1'b1;
                            for (int k = 0; k < 3; k++) begin
                                if (|hit[k]) r_len[k] <= r_len[k] - 1'b1;
                                // close the gap: pull each cell at or after the removed one up from its successor
                                for (int j = 0; j < SLOTS - 1; j++) begin
                                    if (past[k][j]) begin
                                        r_rs[k][j] <= r_rs[k][j+1];
                                        r_rk[k][j] <= r_rk[k][j+1];
                                    end
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_ok  <= r_ok;
            r_o_asg <= r_asg;
            r_o_pay <= r_shown;
            r_o_live <= 6'(r_live);
            for (int k = 0; k < 3; k++) begin
                r_o_head[k] <= (r_len[k] == '0) ? 6'h3F : 6'(r_rs[k][0]);
            end
        end
    end

    assign o_ok               = r_o_ok;
    assign o_slot_assigned    = 5'(r_o_asg);
    assign o_entry_location   = r_o_pay.location;
    assign o_entry_food       = r_o_pay.food;
    assign o_entry_production = r_o_pay.production;
    assign o_entry_gold       = r_o_pay.gold;
    assign o_head_food        = r_o_head[0];
    assign o_head_production  = r_o_head[1];
    assign o_head_gold        = r_o_head[2];
    assign o_live_count       = r_o_live;

    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_used) else $error("live count above used count");
    a_len_le_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len[0] <= r_live && r_len[1] <= r_live && r_len[2] <= r_live)
        else $error("rank list longer than live count");
    a_live_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_live)) else $error("valid bits disagree with count");
endmodule

>>> tb/triple_ranked_slot_table_tb.sv
// Testbench for the triple ranked slot table: directed table, table fill, then random words,
// each result checked against an in-bench ranked-list predictor.
// Depends on trst_pkg and triple_ranked_slot_table.
module triple_ranked_slot_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import trst_pkg::*;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  slot_index;
        logic [31:0] location;
        logic [7:0]  food;
        logic [7:0]  production;
        logic [7:0]  gold;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [4:0]  slot_assigned;
        logic [31:0] location;
        logic [7:0]  food;
        logic [7:0]  production;
        logic [7:0]  gold;
        logic [5:0]  head_food;
        logic [5:0]  head_production;
        logic [5:0]  head_gold;
        logic [5:0]  live_count;
    } t_resp;

    // directed row: chk says the typed result is compared as well
    typedef struct packed {
        t_req  req;
        logic  chk;
        t_resp resp;
    } t_row;

    localparam int N_RANDOM = 1300;
    localparam int LIMIT = 400000;
    localparam logic [5:0] NO_HEAD = 6'h3F;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_CLEAR;
    logic [4:0]  i_slot_index = '0;
    logic [31:0] i_location = '0;
    logic [7:0]  i_food = '0;
    logic [7:0]  i_production = '0;
    logic [7:0]  i_gold = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic        o_ok;
    logic [4:0]  o_slot_assigned;
    logic [31:0] o_entry_location;
    logic [7:0]  o_entry_food, o_entry_production, o_entry_gold;
    logic signed [5:0] o_head_food, o_head_production, o_head_gold;
    logic [5:0]  o_live_count;

    triple_ranked_slot_table u_dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    logic     occupied [SLOTS];
    t_payload stored [SLOTS];
    int       ranking [3][$];
    int       next_slot, live;

    t_resp awaited_q [$];
    t_resp typed_q [$];
    bit    typed_chk_q [$];
    int    errors = 0;
    int    cycle = 0;
    bit    quiet = 0;
    bit    hold_off = 0;

    function automatic logic [23:0] key_of(int k, t_payload p);
        case (k)
            0:       return {p.food, p.production, p.gold};
            1:       return {p.production, p.food, p.gold};
            default: return {p.gold, p.food, p.production};
        endcase
    endfunction

    function automatic logic [7:0] lead_of(int k, t_payload p);
        logic [23:0] kv;
        kv = key_of(k, p);
        return kv[23:16];
    endfunction

    function automatic t_resp predict_table(t_req r);
        t_resp    res;
        t_payload p;
        int       pos;
        res = '0;
        case (r.opcode)
            OP_CLEAR: begin
                foreach (occupied[i]) occupied[i] = 1'b0;
                for (int k = 0; k < 3; k++) ranking[k].delete();
                next_slot = 0;
                live = 0;
                res.ok = 1'b1;
            end
            OP_INSERT: begin
                if (next_slot < SLOTS) begin
                    p.location = r.location;
                    p.food = r.food;
                    p.production = r.production;
                    p.gold = r.gold;
                    stored[next_slot] = p;
                    occupied[next_slot] = 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        if (lead_of(k, p) != 0) begin
                            pos = ranking[k].size();
                            while (pos > 0 &&
                                   key_of(k, p) > key_of(k, stored[ranking[k][pos-1]]))
                                pos--;
                            ranking[k].insert(pos, next_slot);
                        end
                    end
                    res.ok = 1'b1;
                    res.slot_assigned = next_slot[4:0];
                    next_slot++;
                    live++;
                end
            end
            default: begin
                if (occupied[r.slot_index]) begin
                    p = stored[r.slot_index];
                    res.ok = 1'b1;
                    res.location = p.location;
                    res.food = p.food;
                    res.production = p.production;
                    res.gold = p.gold;
                    if (r.opcode == OP_REMOVE) begin
                        occupied[r.slot_index] = 1'b0;
                        live--;
                        for (int k = 0; k < 3; k++)
                            foreach (ranking[k][j])
                                if (ranking[k][j] == r.slot_index) begin
                                    ranking[k].delete(j);
                                    break;
                                end
                    end
                end
            end
        endcase
        res.head_food = ranking[0].size() ? ranking[0][0][5:0] : NO_HEAD;
        res.head_production = ranking[1].size() ? ranking[1][0][5:0] : NO_HEAD;
        res.head_gold = ranking[2].size() ? ranking[2][0][5:0] : NO_HEAD;
        res.live_count = live[5:0];
        return res;
    endfunction

    // drive one word and wait for it to be taken
    task automatic send_word(t_req r, bit chk, t_resp typed);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= r.opcode;
        i_slot_index <= r.slot_index;
        i_location <= r.location;
        i_food <= r.food;
        i_production <= r.production;
        i_gold <= r.gold;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        awaited_q.push_back(predict_table(r));
        typed_q.push_back(typed);
        typed_chk_q.push_back(chk);
    endtask

    function automatic t_req rand_word(bit mostly_live);
        t_req r;
        int   sel;
        r.location = $urandom();
        sel = $urandom_range(0, 3);
        r.food = sel == 0 ? 8'd0 : sel == 1 ? 8'hFF : 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 3);
        r.production = sel == 0 ? 8'd0 : sel == 1 ? 8'(r.food) :
                       8'($urandom_range(0, 255));
        sel = $urandom_range(0, 3);
        r.gold = sel == 0 ? 8'd0 : sel == 1 ? 8'($urandom_range(0, 3)) :
                 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 2) r.opcode = OP_CLEAR;
        else if (sel < 50) r.opcode = OP_INSERT;
        else if (sel < 75) r.opcode = OP_REMOVE;
        else r.opcode = OP_READ;
        // aim mostly at used slots so removes and reads hit live entries
        if (mostly_live && next_slot > 0 && $urandom_range(0, 3) != 0)
            r.slot_index = 5'($urandom_range(0, next_slot - 1));
        else
            r.slot_index = 5'($urandom_range(0, 31));
        return r;
    endfunction

    function automatic t_row mk(logic [1:0] op, logic [4:0] idx, logic [31:0] loc,
                                logic [7:0] f, logic [7:0] pr, logic [7:0] g,
                                logic chk, t_resp typed);
        t_row row;
        row.req = '{op, idx, loc, f, pr, g};
        row.chk = chk;
        row.resp = typed;
        return row;
    endfunction

    // stimulus
    initial begin
        t_row  rows [$];
        t_resp none;
        t_req  r;
        none = '0;
        foreach (occupied[i]) occupied[i] = 1'b0;
        next_slot = 0;
        live = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(mk(OP_READ, 5'd0, 0, 0, 0, 0, 1,
                          '{0, 0, 0, 0, 0, 0, NO_HEAD, NO_HEAD, NO_HEAD, 0}));
        rows.push_back(mk(OP_REMOVE, 5'd31, 0, 0, 0, 0, 1,
                          '{0, 0, 0, 0, 0, 0, NO_HEAD, NO_HEAD, NO_HEAD, 0}));
        rows.push_back(mk(OP_INSERT, 5'd0, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 1,
                          '{1, 0, 0, 0, 0, 0, 0, 0, 0, 1}));
        rows.push_back(mk(OP_INSERT, 5'd0, 32'h0, 8'h0, 8'h0, 8'h0, 1,
                          '{1, 1, 0, 0, 0, 0, 0, 0, 0, 2}));
        rows.push_back(mk(OP_INSERT, 5'd0, 32'h1234, 8'hFF, 8'hFF, 8'hFF, 0, none));
        rows.push_back(mk(OP_INSERT, 5'd0, 32'h55AA, 8'h01, 8'h00, 8'hFE, 0, none));
        rows.push_back(mk(OP_INSERT, 5'd0, 32'hAA55, 8'h00, 8'h80, 8'h00, 0, none));
        rows.push_back(mk(OP_READ, 5'd0, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(OP_REMOVE, 5'd0, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(OP_REMOVE, 5'd0, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(OP_READ, 5'd1, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(OP_CLEAR, 5'd31, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 1,
                          '{1, 0, 0, 0, 0, 0, NO_HEAD, NO_HEAD, NO_HEAD, 0}));
        foreach (rows[i]) send_word(rows[i].req, rows[i].chk, rows[i].resp);

        // fill the table, free a slot, then a full-table insert must fail
        for (int i = 0; i < 33; i++) begin
            r = rand_word(0);
            r.opcode = OP_INSERT;
            send_word(r, 0, none);
        end
        send_word('{OP_REMOVE, 5'd7, 0, 0, 0, 0}, 0, none);
        send_word('{OP_INSERT, 5'd0, 32'h1, 8'h1, 8'h1, 8'h1}, 0, none);
        send_word('{OP_READ, 5'd31, 0, 0, 0, 0}, 0, none);

        // pause until drained, then random words
        i_valid <= 1'b0;
        while (awaited_q.size() != 0) @(posedge i_clk);
        send_word('{OP_CLEAR, 5'd0, 0, 0, 0, 0}, 0, none);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400) hold_off = 1;
            if (n == N_RANDOM - 150) quiet = 1;
            send_word(rand_word(1), 0, none);
        end

        i_valid <= 1'b0;
        while (awaited_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // receiver stall bursts, with one long hold-off
    initial begin
        int burst;
        @(posedge i_rst_n);
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                hold_off = 0;
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 12);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_resp want, got;
        bit    chk;
        t_resp typed;
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_ok, o_slot_assigned, o_entry_location, o_entry_food,
                    o_entry_production, o_entry_gold, o_head_food, o_head_production,
                    o_head_gold, o_live_count};
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected result word, actual %0h", $time, got);
                errors++;
            end else begin
                want = awaited_q.pop_front();
                typed = typed_q.pop_front();
                chk = typed_chk_q.pop_front();
                if (chk && typed !== want) begin
                    $display("%0t: typed row disagrees: expected %0h predicted %0h",
                             $time, typed, want);
                    errors++;
                end
                compare_field("ok", want.ok, got.ok);
                compare_field("slot_assigned", want.slot_assigned, got.slot_assigned);
                compare_field("entry_location", want.location, got.location);
                compare_field("entry_food", want.food, got.food);
                compare_field("entry_production", want.production, got.production);
                compare_field("entry_gold", want.gold, got.gold);
                compare_field("head_food", want.head_food, got.head_food);
                compare_field("head_production", want.head_production,
                              got.head_production);
                compare_field("head_gold", want.head_gold, got.head_gold);
                compare_field("live_count", want.live_count, got.live_count);
            end
        end
    end
endmodule
